// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands. Each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Antecedent implies consequent in the cycle after.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/rrab_pkg.sv
// ----------------------------------------------------------------------------
// rrab_pkg
// Constants and channel widening helpers for the rotated RGB565 blit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrab_pkg;

    // Default landscape view
    localparam int VIEW_WIDTH_DEF  = 1280;
    localparam int VIEW_HEIGHT_DEF = 720;

    // Register indexes
    localparam logic [1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_X = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd2;

    localparam logic [15:0] FG_COLOR_RST = 16'hFFFF;

    // Coverage thresholds
    localparam logic [7:0] ALPHA_MAX    = 8'd255;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd250;

    // floor(c*255/31) and floor(c*255/63) as reciprocal multiplies, shift 22
    localparam int          WIDEN_SHIFT = 22;
    localparam logic [31:0] WIDEN5_MUL  = 32'd34501755;  // 255 * ceil(2^22/31)
    localparam logic [31:0] WIDEN6_MUL  = 32'd16977135;  // 255 * ceil(2^22/63)

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb888_t;

    function automatic logic [7:0] widen5(input logic [4:0] c);
        logic [31:0] prod;
        prod = 32'(c) * WIDEN5_MUL;
        return prod[WIDEN_SHIFT+7:WIDEN_SHIFT];
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] c);
        logic [31:0] prod;
        prod = 32'(c) * WIDEN6_MUL;
        return prod[WIDEN_SHIFT+7:WIDEN_SHIFT];
    endfunction

    function automatic rgb888_t widen565(input logic [15:0] p);
        rgb888_t w;
        w.r = widen5(p[15:11]);
        w.g = widen6(p[10:5]);
        w.b = widen5(p[4:0]);
        return w;
    endfunction

endpackage

// File: rtl/rotated_rgb565_alpha_blit.sv
// ----------------------------------------------------------------------------
// rotated_rgb565_alpha_blit
// Places coverage samples of a text bitmap into a rotated RGB565 framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one coverage sample per transfer with
//   its bitmap col/row, coverage and the current background pixel.
//   Output channel (out_valid/out_ready): exactly one framebuffer write per
//   sample; write_enable low (address and pixel zero) for zero coverage or a
//   position outside the landscape view.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0
//   fg_color, 1 origin_x, 2 origin_y, index 3 is ignored. Write only while
//   the pipeline is empty.
//   Three register stages (widen, multiply, add) lie between the input
//   transfer and out_valid; one sample per clock while out_ready is high.
//   Reset: pipeline empties, fg_color returns to white, origins to zero.
//   Stall: each stage holds while its successor is full and not advancing; a
//   stalled output keeps the input side open until all three stages fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rotated_rgb565_alpha_blit #(
    parameter int VIEW_WIDTH  = rrab_pkg::VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT = rrab_pkg::VIEW_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // samples
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [10:0] col,
    input  logic [9:0]  row,
    input  logic [7:0]  coverage,
    input  logic [15:0] background,
    // framebuffer writes
    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_enable,
    output logic [19:0] address,
    output logic [15:0] pixel
);

    localparam int X_W = $clog2(VIEW_WIDTH);
    localparam int Y_W = $clog2(VIEW_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        fg_color_reg;
    logic signed [11:0] origin_x_reg;
    logic signed [11:0] origin_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg <= rrab_pkg::FG_COLOR_RST;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rrab_pkg::CFG_FG_COLOR: fg_color_reg <= cfg_data;
                rrab_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data[11:0];
                rrab_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data[11:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage advances when its successor is empty
    // or advancing itself.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    assign s3_ready = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: landscape position, coverage class, widen channels to 8 bits
    // ------------------------------------------------------------------
    logic signed [12:0]  s1_lx_reg;
    logic signed [12:0]  s1_ly_reg;
    logic [7:0]          s1_alpha_reg;
    logic                s1_opaque_reg;
    rrab_pkg::rgb888_t   s1_fg_reg;
    rrab_pkg::rgb888_t   s1_bg_reg;

    logic signed [12:0]  s1_lx_next;
    logic signed [12:0]  s1_ly_next;

    assign s1_lx_next = 13'(origin_x_reg) + $signed({2'b00, col});
    assign s1_ly_next = 13'(origin_y_reg) + $signed({3'b000, row});

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_lx_reg     <= s1_lx_next;
            s1_ly_reg     <= s1_ly_next;
            s1_alpha_reg  <= coverage;
            s1_opaque_reg <= (coverage >= rrab_pkg::ALPHA_OPAQUE);
            s1_fg_reg     <= rrab_pkg::widen565(fg_color_reg);
            s1_bg_reg     <= rrab_pkg::widen565(background);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clip, rotated row base, blend products
    // ------------------------------------------------------------------
    logic               s1_in_x;
    logic               s1_in_y;
    logic [7:0]         s1_inv_alpha;

    assign s1_in_x = !s1_lx_reg[12] && ({1'b0, s1_lx_reg[11:0]} < 13'(VIEW_WIDTH));
    assign s1_in_y = !s1_ly_reg[12] && ({1'b0, s1_ly_reg[11:0]} < 13'(VIEW_HEIGHT));
    assign s1_inv_alpha = rrab_pkg::ALPHA_MAX - s1_alpha_reg;

    logic               s2_we_reg;
    logic               s2_opaque_reg;
    logic [7:0]         s2_alpha_reg;
    logic [19:0]        s2_base_reg;
    logic [Y_W-1:0]     s2_revy_reg;
    logic [15:0]        s2_fr_reg;
    logic [15:0]        s2_fg_reg;
    logic [15:0]        s2_fb_reg;
    logic [15:0]        s2_br_reg;
    logic [15:0]        s2_bgr_reg;
    logic [15:0]        s2_bb_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_we_reg     <= (s1_alpha_reg != '0) && s1_in_x && s1_in_y;
            s2_opaque_reg <= s1_opaque_reg;
            s2_alpha_reg  <= s1_alpha_reg;
            s2_base_reg   <= 20'(32'(s1_lx_reg[X_W-1:0]) * 32'(VIEW_HEIGHT));
            s2_revy_reg   <= Y_W'(VIEW_HEIGHT - 1) - s1_ly_reg[Y_W-1:0];
            s2_fr_reg     <= s1_fg_reg.r * s1_alpha_reg;
            s2_fg_reg     <= s1_fg_reg.g * s1_alpha_reg;
            s2_fb_reg     <= s1_fg_reg.b * s1_alpha_reg;
            s2_br_reg     <= s1_bg_reg.r * s1_inv_alpha;
            s2_bgr_reg    <= s1_bg_reg.g * s1_inv_alpha;
            s2_bb_reg     <= s1_bg_reg.b * s1_inv_alpha;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum, repack, final address; output register
    // ------------------------------------------------------------------
    logic [15:0] s2_sum_r;
    logic [15:0] s2_sum_g;
    logic [15:0] s2_sum_b;
    logic [15:0] s2_blend;
    logic [15:0] pixel_next;
    logic [19:0] address_next;

    assign s2_sum_r = s2_fr_reg + s2_br_reg;
    assign s2_sum_g = s2_fg_reg + s2_bgr_reg;
    assign s2_sum_b = s2_fb_reg + s2_bb_reg;
    // take the top bits of each >>8 result
    assign s2_blend = {s2_sum_r[15:11], s2_sum_g[15:10], s2_sum_b[15:11]};

    always_comb
    begin
        pixel_next   = '0;
        address_next = '0;
        if (s2_we_reg)
        begin
            address_next = s2_base_reg + 20'(s2_revy_reg);
            pixel_next   = s2_opaque_reg ? fg_color_reg : s2_blend;
        end
    end

    logic        write_enable_reg;
    logic [19:0] address_reg;
    logic [15:0] pixel_reg;

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            write_enable_reg <= s2_we_reg;
            address_reg      <= address_next;
            pixel_reg        <= pixel_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = write_enable_reg;
    assign address      = address_reg;
    assign pixel        = pixel_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_no_write_zero, out_valid_reg && !write_enable_reg,
                  (address_reg == '0) && (pixel_reg == '0))
    `ASSERT_IMPLY(a_full_when_blocked, !in_ready,
                  s1_valid_reg && s2_valid_reg && out_valid_reg)
    `ASSERT_IMPLY(a_we_needs_alpha, s2_valid_reg && s2_we_reg, s2_alpha_reg != '0)
    `ASSERT_NEXT(a_s1_advance, s1_valid_reg && s2_ready, s2_valid_reg)
    `ASSERT_NEXT(a_s2_advance, s2_valid_reg && s3_ready, out_valid_reg)

endmodule
